// File: hdl/breathing_led_color_generator_assert.svh
// Assertion macros for the breathing LED color generator.
`ifndef BREATHING_LED_COLOR_GENERATOR_ASSERT_SVH
`define BREATHING_LED_COLOR_GENERATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BLCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BLCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/blcg_pkg.sv
// Shared constants, command types and tables for the breathing LED color generator.
package blcg_pkg;

    localparam int PHASE_BITS_DEF    = 10;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int ELAPSED_W   = 8;
    localparam int COLOR_W     = 8;
    localparam int INTENSITY_W = 8;
    localparam int PERIOD_W    = 16;
    localparam int SUM_W       = PERIOD_W + 1;
    localparam int DIV_CNT_W   = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LANES       = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD = 5'd17;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_RED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_GREEN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_BLUE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_MS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_ON   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_ENABLE = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN        = 3'd7;

    localparam logic [PERIOD_W-1:0]    MIN_PERIOD      = 16'd200;
    localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = 16'd1000;
    localparam logic [INTENSITY_W-1:0] INTENSITY_RESET = 8'd255;
    localparam logic [COLOR_W-1:0]     COLOR_MAX       = 8'd255;

    // Q30 fixed point; 1.0 needs 31 bits
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // floor(x / 255) == (x * 32897) >> 23 for any 16-bit x
    localparam logic [15:0] DIV255_MUL   = 16'd32897;
    localparam int          DIV255_SHIFT = 23;

    localparam int HIDX_W = 3;
    localparam logic [HIDX_W-1:0] HIDX_LAST = 3'd4;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_FRAC   = 4'd2;
    localparam logic [OP_W-1:0] OP_THETA  = 4'd3;
    localparam logic [OP_W-1:0] OP_T2     = 4'd4;
    localparam logic [OP_W-1:0] OP_HMUL   = 4'd5;
    localparam logic [OP_W-1:0] OP_HREC   = 4'd6;
    localparam logic [OP_W-1:0] OP_HFIX   = 4'd7;
    localparam logic [OP_W-1:0] OP_SIN    = 4'd8;
    localparam logic [OP_W-1:0] OP_SQ     = 4'd9;
    localparam logic [OP_W-1:0] OP_SQ2    = 4'd10;
    localparam logic [OP_W-1:0] OP_ENVMUL = 4'd11;
    localparam logic [OP_W-1:0] OP_ENV    = 4'd12;
    localparam logic [OP_W-1:0] OP_CH     = 4'd13;
    localparam logic [OP_W-1:0] OP_PROD   = 4'd14;
    localparam logic [OP_W-1:0] OP_OUT    = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HIDX_W-1:0] hidx;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_stat_t;

    // Horner divisors, innermost first
    function automatic logic [6:0] horner_k(input logic [HIDX_W-1:0] idx);
        logic [6:0] k;
        case (idx)
            3'd0:    k = 7'd110;
            3'd1:    k = 7'd72;
            3'd2:    k = 7'd42;
            3'd3:    k = 7'd20;
            3'd4:    k = 7'd6;
            default: k = 7'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / k) for each Horner divisor
    function automatic logic [31:0] horner_recip(input logic [HIDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0:    r = 32'd39045157;
            3'd1:    r = 32'd59652323;
            3'd2:    r = 32'd102261126;
            3'd3:    r = 32'd214748364;
            3'd4:    r = 32'd715827882;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/breathing_led_color_generator.sv
// Breathing LED color generator: sin^4 envelope on a base color.
// One request at a time: a new request is taken only once the previous one has gone
// through the bit-serial divider (phase wrap, then quantize) and the five-step Horner
// sine, and its result has been loaded.
// Reset (rst_n, async low): phase 0, registers at their reset values, no result pending.
`include "breathing_led_color_generator_assert.svh"

module breathing_led_color_generator #(
    parameter int PHASE_BITS    = blcg_pkg::PHASE_BITS_DEF,
    parameter int FRACTION_BITS = blcg_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [blcg_pkg::ELAPSED_W-1:0]     elapsed_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [blcg_pkg::COLOR_W-1:0]       out_red,
    output logic [blcg_pkg::COLOR_W-1:0]       out_green,
    output logic [blcg_pkg::COLOR_W-1:0]       out_blue,
    output logic                               lit,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [blcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [blcg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    blcg_pkg::dp_cmd_t   cmd;
    blcg_pkg::dp_stat_t  stat;
    logic                cfg_we;
    logic [blcg_pkg::COLOR_W-1:0] color_any;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign color_any = out_red | out_green | out_blue;

    blcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    blcg_dp #(
        .PHASE_BITS    (PHASE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .elapsed_ms (elapsed_ms),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .lit        (lit)
    );

    `BLCG_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall, "idle after request")
    `BLCG_ASSERT_NOW(a_divider_idle, !in_stall, !stat.div_busy, "divider busy while idle")
    `BLCG_ASSERT_NOW(a_dark_is_black, out_valid && !lit, color_any == '0, "dark result has color")

endmodule

// File: hdl/blcg_div.sv
// Restoring divider, one quotient bit per cycle, shared by the phase wrap and quantizer.
module blcg_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [blcg_pkg::SUM_W-1:0]       num,
    input  logic [blcg_pkg::PERIOD_W-1:0]    rem_init,
    input  logic [blcg_pkg::PERIOD_W-1:0]    den,
    input  logic [blcg_pkg::DIV_CNT_W-1:0]   steps,
    output logic                             busy,
    output logic [blcg_pkg::SUM_W-1:0]       quot,
    output logic [blcg_pkg::PERIOD_W-1:0]    rem
);

    logic                            busy_reg;
    logic [blcg_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [blcg_pkg::SUM_W-1:0]      num_reg;
    logic [blcg_pkg::SUM_W-1:0]      quot_reg;
    logic [blcg_pkg::PERIOD_W-1:0]   rem_reg;
    logic [blcg_pkg::PERIOD_W-1:0]   den_reg;

    logic [blcg_pkg::PERIOD_W:0]     trial;
    logic [blcg_pkg::PERIOD_W:0]     diff;
    logic                            ge;
    logic [blcg_pkg::PERIOD_W-1:0]   rem_next;

    assign trial    = {rem_reg, num_reg[blcg_pkg::SUM_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[blcg_pkg::PERIOD_W-1:0] : trial[blcg_pkg::PERIOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            rem_reg  <= rem_init;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[blcg_pkg::SUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[blcg_pkg::SUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// File: hdl/blcg_dp.sv
// Datapath: configuration registers, phase counter, sine envelope and color scaling.
module blcg_dp #(
    parameter int PHASE_BITS    = blcg_pkg::PHASE_BITS_DEF,
    parameter int FRACTION_BITS = blcg_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  blcg_pkg::dp_cmd_t                  cmd,
    output blcg_pkg::dp_stat_t                 stat,
    input  logic [blcg_pkg::ELAPSED_W-1:0]     elapsed_ms,
    input  logic                               cfg_we,
    input  logic [blcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [blcg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [blcg_pkg::COLOR_W-1:0]       out_red,
    output logic [blcg_pkg::COLOR_W-1:0]       out_green,
    output logic [blcg_pkg::COLOR_W-1:0]       out_blue,
    output logic                               lit
);

    localparam int PB = PHASE_BITS;
    localparam int F  = FRACTION_BITS;

    localparam logic [PB:0] PHASE_FULL = {1'b1, {PB{1'b0}}};
    localparam logic [PB:0] PHASE_HALF = {2'b01, {(PB-1){1'b0}}};
    localparam logic [blcg_pkg::DIV_CNT_W-1:0] STEPS_FRAC = PB[blcg_pkg::DIV_CNT_W-1:0];

    localparam int          FLOOR_INT = (4 * (1 << F) + 50) / 100;
    localparam logic [F:0]  FLOOR_F   = FLOOR_INT[F:0];
    localparam int          SPAN_INT  = (1 << F) - FLOOR_INT;
    localparam logic [F-1:0] ENV_SPAN = SPAN_INT[F-1:0];
    localparam logic [31:0] ROUND_G   = 32'd1 << (29 - F);
    localparam logic [2*F+1:0] ROUND_ENV = {{(F+2){1'b0}}, 1'b1, {(F-1){1'b0}}};

    // configuration
    logic [blcg_pkg::COLOR_W-1:0]     base_red_reg;
    logic [blcg_pkg::COLOR_W-1:0]     base_green_reg;
    logic [blcg_pkg::COLOR_W-1:0]     base_blue_reg;
    logic [blcg_pkg::PERIOD_W-1:0]    period_ms_reg;
    logic [blcg_pkg::INTENSITY_W-1:0] intensity_reg;
    logic                             force_on_reg;
    logic                             led_enable_reg;
    logic                             run_reg;

    logic [blcg_pkg::PERIOD_W-1:0]    phase_reg;

    // working registers
    logic [30:0]     theta_reg;
    logic [31:0]     t2_reg;
    logic [30:0]     t_reg;
    logic [31:0]     x_reg;
    logic [31:0]     q0_reg;
    logic [30:0]     s_reg;
    logic [2*F:0]    gm_reg;
    logic [F:0]      env_reg;
    logic [blcg_pkg::COLOR_W-1:0] ch_reg [blcg_pkg::LANES];
    logic [15:0]     p_reg  [blcg_pkg::LANES];
    logic [blcg_pkg::COLOR_W-1:0] out_reg [blcg_pkg::LANES];
    logic            lit_reg;

    logic [blcg_pkg::PERIOD_W-1:0]  period_eff;
    logic                           lit_now;

    logic                           div_start;
    logic [blcg_pkg::SUM_W-1:0]     div_num;
    logic [blcg_pkg::PERIOD_W-1:0]  div_rem_init;
    logic [blcg_pkg::DIV_CNT_W-1:0] div_steps;
    logic                           div_busy;
    logic [blcg_pkg::SUM_W-1:0]     div_quot;
    logic [blcg_pkg::PERIOD_W-1:0]  div_rem;

    logic [PB:0]       q_ext;
    logic [PB:0]       m_wide;
    logic [PB+31:0]    theta_prod;
    logic [30:0]       theta_next;
    logic [61:0]       t2_prod;
    logic [31:0]       t2_next;
    logic [62:0]       hx_prod;
    logic [31:0]       x_next;
    logic [63:0]       rec_prod;
    logic [31:0]       q0_next;
    logic [6:0]        hk;
    logic [38:0]       kq_prod;
    logic [31:0]       hrem;
    logic [31:0]       qc;
    logic [30:0]       t_next;
    logic [61:0]       sin_prod;
    logic [31:0]       sin_raw;
    logic [30:0]       sin_next;
    logic [61:0]       sq_prod;
    logic [30:0]       sq_next;
    logic [31:0]       g_round;
    logic [F:0]        gf;
    logic [2*F:0]      gm_next;
    logic [2*F+1:0]    env_sum;
    logic [F:0]        env_next;
    logic [blcg_pkg::COLOR_W-1:0] base_lane [blcg_pkg::LANES];
    logic [F+8:0]      ch_prod [blcg_pkg::LANES];
    logic [8:0]        ch_hi   [blcg_pkg::LANES];
    logic [blcg_pkg::COLOR_W-1:0] ch_next [blcg_pkg::LANES];
    logic [15:0]       p_next  [blcg_pkg::LANES];
    logic [31:0]       o_prod  [blcg_pkg::LANES];
    logic [blcg_pkg::COLOR_W-1:0] out_next [blcg_pkg::LANES];

    assign period_eff = (period_ms_reg < blcg_pkg::MIN_PERIOD) ? blcg_pkg::MIN_PERIOD
                                                               : period_ms_reg;
    assign lit_now = run_reg & (force_on_reg | led_enable_reg);

    // divider: wrap on a new request, then quantize the wrapped phase
    assign div_start    = (cmd.op == blcg_pkg::OP_LOAD) || (cmd.op == blcg_pkg::OP_FRAC);
    assign div_num      = (cmd.op == blcg_pkg::OP_LOAD)
                        ? ({1'b0, phase_reg} + {{(blcg_pkg::SUM_W-blcg_pkg::ELAPSED_W){1'b0}},
                                                elapsed_ms})
                        : '0;
    assign div_rem_init = (cmd.op == blcg_pkg::OP_LOAD) ? '0 : div_rem;
    assign div_steps    = (cmd.op == blcg_pkg::OP_LOAD) ? blcg_pkg::DIV_STEPS_MOD : STEPS_FRAC;

    blcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .rem_init (div_rem_init),
        .den      (period_eff),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign stat.div_busy = div_busy;

    // fold phase into the first quarter wave
    assign q_ext      = {1'b0, div_quot[PB-1:0]};
    assign m_wide     = (q_ext <= PHASE_HALF) ? q_ext : (PHASE_FULL - q_ext);
    assign theta_prod = m_wide[PB-1:0] * blcg_pkg::PI_Q30;
    assign theta_next = theta_prod[PB+30:PB];

    assign t2_prod = theta_reg * theta_reg;
    assign t2_next = t2_prod[61:30];

    // Horner step: t = 1 - ((t2 * t) >> 30) / k, divide by reciprocal plus one fixup
    assign hx_prod  = t2_reg * t_reg;
    assign x_next   = hx_prod[61:30];
    assign rec_prod = x_reg * blcg_pkg::horner_recip(cmd.hidx);
    assign q0_next  = rec_prod[63:32];
    assign hk       = blcg_pkg::horner_k(cmd.hidx);
    assign kq_prod  = q0_reg * hk;
    assign hrem     = x_reg - kq_prod[31:0];
    assign qc       = (hrem >= {25'd0, hk}) ? (q0_reg + 32'd1) : q0_reg;
    assign t_next   = blcg_pkg::Q30_ONE - qc[30:0];

    assign sin_prod = theta_reg * t_reg;
    assign sin_raw  = sin_prod[61:30];
    assign sin_next = (sin_raw > {1'b0, blcg_pkg::Q30_ONE}) ? blcg_pkg::Q30_ONE : sin_raw[30:0];

    assign sq_prod = s_reg * s_reg;
    assign sq_next = sq_prod[60:30];

    // round sin^4 to F bits, then lift onto the floor
    assign g_round  = {1'b0, s_reg} + ROUND_G;
    assign gf       = g_round[30:30-F];
    assign gm_next  = gf * ENV_SPAN;
    assign env_sum  = {1'b0, gm_reg} + ROUND_ENV;
    assign env_next = FLOOR_F + env_sum[2*F:F];

    assign base_lane[0] = base_red_reg;
    assign base_lane[1] = base_green_reg;
    assign base_lane[2] = base_blue_reg;

    always_comb
    begin
        for (int i = 0; i < blcg_pkg::LANES; i++)
        begin
            ch_prod[i]  = base_lane[i] * env_reg;
            ch_hi[i]    = ch_prod[i][F+8:F];
            ch_next[i]  = (ch_hi[i] > {1'b0, blcg_pkg::COLOR_MAX}) ? blcg_pkg::COLOR_MAX
                                                                  : ch_hi[i][7:0];
            p_next[i]   = ch_reg[i] * intensity_reg;
            o_prod[i]   = p_reg[i] * blcg_pkg::DIV255_MUL;
            out_next[i] = lit_now ? o_prod[i][blcg_pkg::DIV255_SHIFT+7:blcg_pkg::DIV255_SHIFT]
                                  : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_red_reg   <= '0;
            base_green_reg <= '0;
            base_blue_reg  <= '0;
            period_ms_reg  <= blcg_pkg::PERIOD_RESET;
            intensity_reg  <= blcg_pkg::INTENSITY_RESET;
            force_on_reg   <= 1'b0;
            led_enable_reg <= 1'b1;
            run_reg        <= 1'b0;
            phase_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    blcg_pkg::REG_BASE_RED:   base_red_reg   <= cfg_data[7:0];
                    blcg_pkg::REG_BASE_GREEN: base_green_reg <= cfg_data[7:0];
                    blcg_pkg::REG_BASE_BLUE:  base_blue_reg  <= cfg_data[7:0];
                    blcg_pkg::REG_PERIOD_MS:  period_ms_reg  <= cfg_data;
                    blcg_pkg::REG_INTENSITY:  intensity_reg  <= cfg_data[7:0];
                    blcg_pkg::REG_FORCE_ON:   force_on_reg   <= cfg_data[0];
                    blcg_pkg::REG_LED_ENABLE: led_enable_reg <= cfg_data[0];
                    blcg_pkg::REG_RUN:        run_reg        <= cfg_data[0];
                    default:                  ;
                endcase
            end
            if (cmd.op == blcg_pkg::OP_FRAC)
            begin
                phase_reg <= div_rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            blcg_pkg::OP_THETA:  theta_reg <= theta_next;
            blcg_pkg::OP_T2:
            begin
                t2_reg <= t2_next;
                t_reg  <= blcg_pkg::Q30_ONE;
            end
            blcg_pkg::OP_HMUL:   x_reg   <= x_next;
            blcg_pkg::OP_HREC:   q0_reg  <= q0_next;
            blcg_pkg::OP_HFIX:   t_reg   <= t_next;
            blcg_pkg::OP_SIN:    s_reg   <= sin_next;
            blcg_pkg::OP_SQ:     s_reg   <= sq_next;
            blcg_pkg::OP_SQ2:    s_reg   <= sq_next;
            blcg_pkg::OP_ENVMUL: gm_reg  <= gm_next;
            blcg_pkg::OP_ENV:    env_reg <= env_next;
            blcg_pkg::OP_CH:
            begin
                for (int i = 0; i < blcg_pkg::LANES; i++)
                begin
                    ch_reg[i] <= ch_next[i];
                end
            end
            blcg_pkg::OP_PROD:
            begin
                for (int i = 0; i < blcg_pkg::LANES; i++)
                begin
                    p_reg[i] <= p_next[i];
                end
            end
            blcg_pkg::OP_OUT:
            begin
                for (int i = 0; i < blcg_pkg::LANES; i++)
                begin
                    out_reg[i] <= out_next[i];
                end
                lit_reg <= lit_now;
            end
            default: ;
        endcase
    end

    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign lit       = lit_reg;

endmodule

// File: hdl/blcg_ctrl.sv
// Controller: sequences the datapath for one request and owns the result handshake.
module blcg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output blcg_pkg::dp_cmd_t   cmd,
    input  blcg_pkg::dp_stat_t  stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WMOD   = 4'd1;
    localparam logic [3:0] S_WFRAC  = 4'd2;
    localparam logic [3:0] S_T2     = 4'd3;
    localparam logic [3:0] S_HMUL   = 4'd4;
    localparam logic [3:0] S_HREC   = 4'd5;
    localparam logic [3:0] S_HFIX   = 4'd6;
    localparam logic [3:0] S_SIN    = 4'd7;
    localparam logic [3:0] S_SQ     = 4'd8;
    localparam logic [3:0] S_SQ2    = 4'd9;
    localparam logic [3:0] S_ENVMUL = 4'd10;
    localparam logic [3:0] S_ENV    = 4'd11;
    localparam logic [3:0] S_CH     = 4'd12;
    localparam logic [3:0] S_PROD   = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic [blcg_pkg::HIDX_W-1:0]   hidx_reg;
    logic [blcg_pkg::HIDX_W-1:0]   hidx_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        hidx_next      = hidx_reg;
        cmd.op         = blcg_pkg::OP_NONE;
        cmd.hidx       = hidx_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = blcg_pkg::OP_LOAD;
                    state_next = S_WMOD;
                end
            end
            S_WMOD:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = blcg_pkg::OP_FRAC;
                    state_next = S_WFRAC;
                end
            end
            S_WFRAC:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = blcg_pkg::OP_THETA;
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                cmd.op     = blcg_pkg::OP_T2;
                hidx_next  = '0;
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.op     = blcg_pkg::OP_HMUL;
                state_next = S_HREC;
            end
            S_HREC:
            begin
                cmd.op     = blcg_pkg::OP_HREC;
                state_next = S_HFIX;
            end
            S_HFIX:
            begin
                cmd.op = blcg_pkg::OP_HFIX;
                if (hidx_reg == blcg_pkg::HIDX_LAST)
                begin
                    state_next = S_SIN;
                end
                else
                begin
                    hidx_next  = hidx_reg + 1'b1;
                    state_next = S_HMUL;
                end
            end
            S_SIN:
            begin
                cmd.op     = blcg_pkg::OP_SIN;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = blcg_pkg::OP_SQ;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.op     = blcg_pkg::OP_SQ2;
                state_next = S_ENVMUL;
            end
            S_ENVMUL:
            begin
                cmd.op     = blcg_pkg::OP_ENVMUL;
                state_next = S_ENV;
            end
            S_ENV:
            begin
                cmd.op     = blcg_pkg::OP_ENV;
                state_next = S_CH;
            end
            S_CH:
            begin
                cmd.op     = blcg_pkg::OP_CH;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.op     = blcg_pkg::OP_PROD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // load only once the previous result has left
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = blcg_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hidx_reg      <= hidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
